### rtl/tcc_pkg.sv
// Package for the typed cell comparator: item structs, type codes, fault codes,
// and the decimal limit table. No dependencies.
`timescale 1ns / 1ps
package tcc_pkg;

    typedef struct packed {
        logic [63:0] left_low;
        logic [63:0] left_high;
        logic [4:0]  left_size;
        logic        left_is_null;
        logic [63:0] right_low;
        logic [63:0] right_high;
        logic [4:0]  right_size;
        logic        right_is_null;
    } in_item_t;

    typedef struct packed {
        logic signed [1:0] order;
        logic [1:0]        fault;
    } out_item_t;

    localparam logic [3:0] KIND_INT8  = 4'd0;
    localparam logic [3:0] KIND_INT16 = 4'd1;
    localparam logic [3:0] KIND_INT32 = 4'd2;
    localparam logic [3:0] KIND_INT64 = 4'd3;
    localparam logic [3:0] KIND_DATE  = 4'd4;
    localparam logic [3:0] KIND_TS    = 4'd5;
    localparam logic [3:0] KIND_UINT8 = 4'd6;
    localparam logic [3:0] KIND_UINT16 = 4'd7;
    localparam logic [3:0] KIND_UINT32 = 4'd8;
    localparam logic [3:0] KIND_UINT64 = 4'd9;
    localparam logic [3:0] KIND_F32   = 4'd10;
    localparam logic [3:0] KIND_F64   = 4'd11;
    localparam logic [3:0] KIND_DEC   = 4'd12;
    localparam logic [3:0] KIND_UUID  = 4'd13;

    localparam logic [1:0] REG_TYPE_KIND = 2'd0;
    localparam logic [1:0] REG_PRECISION = 2'd1;
    localparam logic [1:0] REG_NULLS_LAST = 2'd2;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_WIDTH = 2'd1;
    localparam logic [1:0] FAULT_PREC  = 2'd2;

    localparam logic signed [1:0] ORD_LEFT  = -2'sd1;
    localparam logic signed [1:0] ORD_EQUAL = 2'sd0;
    localparam logic signed [1:0] ORD_RIGHT = 2'sd1;

    // Cell byte width per type code; zero marks an unused code.
    function automatic logic [4:0] cell_width(input logic [3:0] k);
        logic [4:0] w;
        case (k)
            KIND_INT8, KIND_UINT8:   w = 5'd1;
            KIND_INT16, KIND_UINT16: w = 5'd2;
            KIND_INT32, KIND_UINT32, KIND_DATE, KIND_F32: w = 5'd4;
            KIND_INT64, KIND_UINT64, KIND_TS, KIND_F64:   w = 5'd8;
            KIND_DEC, KIND_UUID:     w = 5'd16;
            default:                 w = 5'd0;
        endcase
        return w;
    endfunction

    // Ten to the power p, for p up to 38 (fits in 127 bits).
    function automatic logic [127:0] pow10(input logic [5:0] p);
        logic [127:0] v;
        v = 128'd1;
        for (int i = 0; i < 39; i++) begin
            if (i < int'(p)) begin
                v = (v << 3) + (v << 1);
            end
        end
        return v;
    endfunction

    // Constant table of powers of ten, evaluated at elaboration.
    typedef logic [38:0][127:0] pow_tab_t;

    function automatic pow_tab_t pow_tab();
        pow_tab_t t;
        for (int i = 0; i < 39; i++) begin
            t[i] = pow10(6'(i));
        end
        return t;
    endfunction

    localparam pow_tab_t POW10 = pow_tab();

endpackage

### rtl/typed_cell_comparator_core.sv
// Typed cell comparator top level: config registers, input register, compare
// logic and result register with skid. Depends on tcc_pkg.
`timescale 1ns / 1ps
// Items pass through an input register, which feeds the type decode,
// width/precision checks and the three-way compare, and land in a result
// register. A skid register behind it parks one result while the downstream
// side stalls; in_stall is high while it is full. Throughput is one item per
// cycle while in_stall is low. Configuration writes are always ready.
module typed_cell_comparator_core
    import tcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    logic [3:0] kind_reg;
    logic [5:0] prec_reg;
    logic       nulls_last_reg;

    assign cfg_ready = 1'b1;

    // Hold configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            kind_reg       <= KIND_INT64;
            prec_reg       <= 6'd38;
            nulls_last_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TYPE_KIND:  kind_reg <= cfg_data[3:0];
                REG_PRECISION:  prec_reg <= cfg_data;
                REG_NULLS_LAST: nulls_last_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline: input register s1, result register s2, skid register sk.
    in_item_t  s1_reg;
    logic      s1_valid_reg;
    out_item_t s2_reg, sk_reg;
    logic      s2_valid_reg, sk_valid_reg;
    out_item_t res_next;

    logic adv;
    assign adv      = !sk_valid_reg;
    assign in_stall = sk_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
                // Park the result when the output is stalled and the pipe moves.
                if (s2_valid_reg && out_stall) begin
                    sk_valid_reg <= 1'b1;
                end
            end else if (!out_stall) begin
                sk_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            s1_reg <= in_item;
            s2_reg <= res_next;
            if (s2_valid_reg && out_stall) begin
                sk_reg <= s2_reg;
            end
        end
    end

    // Output: skid entry first, then the result register; s2 waits behind
    // the skid while it is full, and drains after it.
    assign out_valid = sk_valid_reg || s2_valid_reg;
    assign out_item  = sk_valid_reg ? sk_reg : s2_reg;

    // Compare logic.
    logic [4:0]   width;
    logic [63:0]  mask;
    logic [127:0] limit;
    logic         chk_prec;

    function automatic logic fits(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [127:0] lim, input logic en);
        logic [127:0] v, m;
        v = {hi, lo};
        m = v[127] ? (~v + 128'd1) : v;
        return !en || (m < lim);
    endfunction

    function automatic logic signed [1:0] cmp(input logic [63:0] a, input logic [63:0] b);
        return (a == b) ? ORD_EQUAL : ((a < b) ? ORD_LEFT : ORD_RIGHT);
    endfunction

    // Map float bits to a key whose unsigned order matches value order.
    function automatic logic [63:0] fkey(input logic [63:0] x);
        return x[63] ? ~x : (x | 64'h8000_0000_0000_0000);
    endfunction

    function automatic logic [63:0] byteswap(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) begin
            r[8*(7-i) +: 8] = x[8*i +: 8];
        end
        return r;
    endfunction

    always_comb begin
        logic [63:0] a, b;
        logic        an, bn, azero, bzero;
        logic        f32;
        logic [1:0]  f;
        logic signed [1:0] o;
        width    = cell_width(kind_reg);
        mask     = (width >= 5'd8) ? '1 : ((64'd1 << {width[2:0], 3'b000}) - 64'd1);
        chk_prec = (kind_reg == KIND_DEC) && (prec_reg < 6'd39);
        limit    = POW10[(prec_reg < 6'd39) ? prec_reg : 6'd0];
        a = s1_reg.left_low & mask;
        b = s1_reg.right_low & mask;
        o = ORD_EQUAL;
        f = FAULT_NONE;
        an = 1'b0; bn = 1'b0; azero = 1'b0; bzero = 1'b0;
        f32 = (kind_reg == KIND_F32);
        if (s1_reg.left_is_null || s1_reg.right_is_null) begin
            if (s1_reg.left_is_null && s1_reg.right_is_null) begin
                o = ORD_EQUAL;
            end else if (s1_reg.left_is_null == nulls_last_reg) begin
                o = ORD_RIGHT;
            end else begin
                o = ORD_LEFT;
            end
        end else if (width == 5'd0 || s1_reg.left_size != width) begin
            f = FAULT_WIDTH;
        end else if (!fits(s1_reg.left_low, s1_reg.left_high, limit, chk_prec)) begin
            f = FAULT_PREC;
        end else if (s1_reg.right_size != width) begin
            f = FAULT_WIDTH;
        end else if (!fits(s1_reg.right_low, s1_reg.right_high, limit, chk_prec)) begin
            f = FAULT_PREC;
        end else begin
            case (kind_reg)
                KIND_INT8, KIND_INT16, KIND_INT32, KIND_INT64, KIND_DATE, KIND_TS: begin
                    // Sign-extend, flip sign, compare unsigned.
                    if ((a & ~(mask >> 1)) != 64'd0) a = a | ~mask;
                    if ((b & ~(mask >> 1)) != 64'd0) b = b | ~mask;
                    o = cmp(a ^ 64'h8000_0000_0000_0000, b ^ 64'h8000_0000_0000_0000);
                end
                KIND_F32, KIND_F64: begin
                    if (f32) begin
                        an = (a[30:23] == 8'hff) && (a[22:0] != '0);
                        bn = (b[30:23] == 8'hff) && (b[22:0] != '0);
                        azero = a[30:0] == '0;
                        bzero = b[30:0] == '0;
                        a = {a[31:0], 32'd0};
                        b = {b[31:0], 32'd0};
                    end else begin
                        an = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
                        bn = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
                        azero = a[62:0] == '0;
                        bzero = b[62:0] == '0;
                    end
                    if (an || bn) begin
                        o = (an == bn) ? ORD_EQUAL : (an ? ORD_RIGHT : ORD_LEFT);
                    end else if (azero && bzero) begin
                        o = ORD_EQUAL;
                    end else begin
                        o = cmp(fkey(a), fkey(b));
                    end
                end
                KIND_DEC: begin
                    if (s1_reg.left_high[63] != s1_reg.right_high[63]) begin
                        o = s1_reg.left_high[63] ? ORD_LEFT : ORD_RIGHT;
                    end else if (s1_reg.left_high != s1_reg.right_high) begin
                        o = cmp(s1_reg.left_high, s1_reg.right_high);
                    end else begin
                        o = cmp(s1_reg.left_low, s1_reg.right_low);
                    end
                end
                KIND_UUID: begin
                    if (s1_reg.left_low != s1_reg.right_low) begin
                        o = cmp(byteswap(s1_reg.left_low), byteswap(s1_reg.right_low));
                    end else begin
                        o = cmp(byteswap(s1_reg.left_high), byteswap(s1_reg.right_high));
                    end
                end
                default: o = cmp(a, b);
            endcase
        end
        res_next.order = o;
        res_next.fault = f;
    end

endmodule

### rtl/tcc_checker.sv
// Port-level checker for typed_cell_comparator_core, bound to the top level.
// Depends on tcc_pkg.
`timescale 1ns / 1ps
module tcc_checker
    import tcc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed under stall");

    // A fault always carries an equal order.
    a_fault_eq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.fault != FAULT_NONE |-> out_item.order == ORD_EQUAL)
        else $error("fault with nonzero order");

    // Fault code 3 never appears.
    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.fault != 2'd3)
        else $error("bad fault code");

    // Order code -2 never appears.
    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.order != -2'sd2)
        else $error("bad order code");

    // Input stall only rises as a result of an output stall.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_stall))
        else $error("input stall without output stall");

endmodule

bind typed_cell_comparator_core tcc_checker u_tcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
